[rtl/iirdf1_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iirdf1_pkg
// Shared constants for the direct form I IIR filter: default sizes,
// coefficient format and configuration register map.
// ----------------------------------------------------------------------------
package iirdf1_pkg;

	// default sizes handed to the top level parameters
	localparam int DEF_MAX_TAPS       = 4;
	localparam int DEF_SAMPLE_BITS    = 16;
	localparam int DEF_COEF_FRAC_BITS = 14;

	// coefficient format and configuration port widths
	localparam int COEF_BITS  = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int TAP_CFG_W  = 3;

	// configuration register map
	localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FWD_COEF_0  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BACK_COEF_1 = 3'd5;

endpackage

[rtl/iir_direct_form1_filter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iir_direct_form1_filter
// Direct form I IIR filter with a configurable tap count, Q2.14 coefficients,
// an exact accumulator, round half up and saturation to the sample width.
// ----------------------------------------------------------------------------
// a new sample is taken only once the last one is written back; one shared multiplier
//   walks the 2N-1 products, two per history entry read from the history ram
// reset: tap_count = MAX_TAPS, b0 = 1.0, other coefficients zero, history empty
// history ram has no clearing pass; a fill count masks entries not yet written
module iir_direct_form1_filter
	import iirdf1_pkg::*;
#(
	parameter int MAX_TAPS       = DEF_MAX_TAPS,
	parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS,
	parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data,
	// sample input channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	// sample output channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] sample_out
);

	// sizes derived from the parameters
	localparam int AW       = $clog2(MAX_TAPS);
	localparam int TAP_W    = $clog2(MAX_TAPS + 1);
	localparam int PROD_W   = SAMPLE_BITS + COEF_BITS;
	localparam int ACC_MIN  = PROD_W + $clog2(2 * MAX_TAPS) + 1;
	localparam int ACC_W    = (ACC_MIN > COEF_FRAC_BITS + 2) ? ACC_MIN : COEF_FRAC_BITS + 2;
	localparam int RAM_W    = 2 * SAMPLE_BITS;

	localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);
	localparam logic signed [ACC_W-1:0] Y_MAX =
		{{(ACC_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
	localparam logic signed [ACC_W-1:0] Y_MIN =
		{{(ACC_W - SAMPLE_BITS + 1){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};
	localparam logic signed [COEF_BITS-1:0] B0_RESET = COEF_BITS'(1) << COEF_FRAC_BITS;

	// sequencer: first tap, then feedforward/feedback pairs per history entry
	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_B0    = 6'b000010,
		S_FX    = 6'b000100,
		S_FY    = 6'b001000,
		S_DRAIN = 6'b010000,
		S_WB    = 6'b100000
	} state_t;

	state_t state_q, state_d;

	// configuration registers
	logic [TAP_W-1:0]            tap_q;
	logic signed [COEF_BITS-1:0] fwd_q  [0:MAX_TAPS-1];
	logic signed [COEF_BITS-1:0] back_q [1:MAX_TAPS-1];

	// ring control
	logic [AW-1:0]    pos_q;
	logic [TAP_W-1:0] fill_q;
	logic [AW-1:0]    k_q;

	// current sample and accumulator
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic signed [ACC_W-1:0]       acc_q;

	// multiplier stage
	logic signed [SAMPLE_BITS-1:0] mul_a;
	logic signed [COEF_BITS-1:0]   mul_b;
	logic                          mul_vld;
	logic                          mul_sub;
	logic signed [PROD_W-1:0]      prod_s1;
	logic                          prod_vld_s1;
	logic                          prod_sub_s1;

	// output register
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] sample_out_q;

	// history ram signals
	logic             ram_we;
	logic [RAM_W-1:0] ram_wdata;
	logic             ram_re;
	logic [AW-1:0]    ram_raddr;
	logic [RAM_W-1:0] ram_rdata;
	logic [AW-1:0]    rd_k;

	logic                          in_beat;
	logic                          tap_wr;
	logic                          last_term;
	logic                          term_ok;
	logic                          out_free;
	logic [TAP_CFG_W-1:0]          tap_raw;
	logic [TAP_W-1:0]              tap_sat;
	logic signed [ACC_W-1:0]       acc_rnd;
	logic signed [ACC_W-1:0]       y_full;
	logic signed [SAMPLE_BITS-1:0] y_sat;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign in_beat   = in_valid && in_ready;
	assign tap_wr    = cfg_valid && (cfg_index == REG_TAP_COUNT);
	assign out_valid = out_valid_q;
	assign sample_out = sample_out_q;
	assign out_free  = !out_valid_q || out_ready;

	// last history entry of this sample reached
	assign last_term = (TAP_W'(k_q) == tap_q - TAP_W'(1));
	// a lag counts only once a sample was written there since the last clear
	assign term_ok   = (TAP_W'(k_q) < fill_q);

	// tap count write: zero reads as one, anything above the maximum clamps
	always_comb begin
		tap_raw = cfg_data[TAP_CFG_W-1:0];
		if (tap_raw == TAP_CFG_W'(0)) begin
			tap_sat = TAP_W'(1);
		end else if (int'(tap_raw) > MAX_TAPS) begin
			tap_sat = TAP_W'(MAX_TAPS);
		end else begin
			tap_sat = TAP_W'(tap_raw);
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q <= TAP_W'(MAX_TAPS);
			for (int i = 0; i < MAX_TAPS; i++) begin
				fwd_q[i] <= (i == 0) ? B0_RESET : '0;
			end
			for (int i = 1; i < MAX_TAPS; i++) begin
				back_q[i] <= '0;
			end
		end else if (cfg_valid) begin
			if (tap_wr) begin
				tap_q <= tap_sat;
			end
			for (int i = 0; i < MAX_TAPS; i++) begin
				if (cfg_index == REG_FWD_COEF_0 + CFG_IDX_W'(i)) begin
					fwd_q[i] <= $signed(cfg_data[COEF_BITS-1:0]);
				end
			end
			for (int i = 1; i < MAX_TAPS; i++) begin
				if (cfg_index == REG_BACK_COEF_1 + CFG_IDX_W'(i - 1)) begin
					back_q[i] <= $signed(cfg_data[COEF_BITS-1:0]);
				end
			end
		end
	end

	// history read address: slot of lag rd_k behind the write position
	assign rd_k = in_beat ? AW'(1) : k_q + AW'(1);

	always_comb begin
		if (TAP_W'(pos_q) >= TAP_W'(rd_k)) begin
			ram_raddr = AW'(TAP_W'(pos_q) - TAP_W'(rd_k));
		end else begin
			ram_raddr = AW'(TAP_W'(pos_q) + tap_q - TAP_W'(rd_k));
		end
	end

	assign ram_re = in_beat || (state_q == S_FY);

	// multiplier operand select
	always_comb begin
		mul_a   = x_q;
		mul_b   = fwd_q[0];
		mul_vld = 1'b0;
		mul_sub = 1'b0;
		case (state_q)
			S_B0: begin
				mul_vld = 1'b1;
			end
			S_FX: begin
				mul_a   = $signed(ram_rdata[RAM_W-1:SAMPLE_BITS]);
				mul_b   = fwd_q[k_q];
				mul_vld = term_ok;
			end
			S_FY: begin
				mul_a   = $signed(ram_rdata[SAMPLE_BITS-1:0]);
				mul_b   = back_q[k_q];
				mul_vld = term_ok;
				mul_sub = 1'b1;
			end
			default: begin
				mul_vld = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_s1     <= mul_a * mul_b;
		prod_sub_s1 <= mul_sub;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_vld_s1 <= 1'b0;
		end else begin
			prod_vld_s1 <= mul_vld;
		end
	end

	// exact accumulator, cleared on each new sample
	always_ff @(posedge clk) begin
		if (in_beat) begin
			acc_q <= '0;
			x_q   <= sample_in;
		end else if (prod_vld_s1) begin
			if (prod_sub_s1) begin
				acc_q <= acc_q - ACC_W'(prod_s1);
			end else begin
				acc_q <= acc_q + ACC_W'(prod_s1);
			end
		end
	end

	// round half up, then clamp to the sample range
	always_comb begin
		acc_rnd = acc_q + ROUND_HALF;
		y_full  = acc_rnd >>> COEF_FRAC_BITS;
		if (y_full > Y_MAX) begin
			y_sat = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
		end else if (y_full < Y_MIN) begin
			y_sat = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
		end else begin
			y_sat = y_full[SAMPLE_BITS-1:0];
		end
	end

	// write back x and y together once the output register can take y
	assign ram_we    = (state_q == S_WB) && out_free;
	assign ram_wdata = {x_q, y_sat};

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_beat) state_d = S_B0;
			end
			S_B0: begin
				state_d = (tap_q == TAP_W'(1)) ? S_DRAIN : S_FX;
			end
			S_FX: begin
				state_d = S_FY;
			end
			S_FY: begin
				state_d = last_term ? S_DRAIN : S_FX;
			end
			S_DRAIN: begin
				state_d = S_WB;
			end
			S_WB: begin
				if (out_free) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			if (in_beat) begin
				k_q <= AW'(1);
			end else if (state_q == S_FY) begin
				k_q <= k_q + AW'(1);
			end
		end
	end

	// ring position and fill count; a tap count write empties the history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			fill_q <= '0;
		end else if (tap_wr) begin
			pos_q  <= '0;
			fill_q <= '0;
		end else begin
			if (in_beat) begin
				fill_q <= (fill_q < tap_q) ? fill_q + TAP_W'(1) : tap_q;
			end
			if (ram_we) begin
				pos_q <= (TAP_W'(pos_q) + TAP_W'(1) == tap_q) ? '0 : pos_q + AW'(1);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ram_we) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_we) begin
			sample_out_q <= y_sat;
		end
	end

	iirdf1_ram #(
		.WIDTH (RAM_W),
		.DEPTH (MAX_TAPS)
	) u_hist_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (pos_q),
		.wr_data (ram_wdata),
		.rd_en   (ram_re),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	// checks
	a_fill_le_taps: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= tap_q)
		else $error("fill count above tap count");

	a_pos_in_ring: assert property (@(posedge clk) disable iff (!arst_n)
		TAP_W'(pos_q) < tap_q)
		else $error("ring position outside the ring");

	a_wb_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (!out_valid_q || out_ready))
		else $error("history written back while the output register is full");

	a_tap_clears: assert property (@(posedge clk) disable iff (!arst_n)
		tap_wr |=> (fill_q == '0) && (pos_q == '0))
		else $error("tap count write did not empty the history");

endmodule

[rtl/iirdf1_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iirdf1_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module iirdf1_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the direct form I IIR filter. A behavioral model of
// the filter predicts each output beat from the accepted input beats and the
// register writes. Directed cases cover defaults, rounding, saturation and
// feedback. Random traffic then runs under several idle mixes, and a long
// output stall checks back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
	import iirdf1_pkg::*;

	localparam int    NTAPS      = DEF_MAX_TAPS;
	localparam int    FRAC       = DEF_COEF_FRAC_BITS;
	localparam longint SAMPLE_MAX = (longint'(1) <<< (DEF_SAMPLE_BITS - 1)) - 1;
	localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
	localparam longint ROUND_HALF = longint'(1) <<< (FRAC - 1);
	localparam int    HOLD_CYCLES = 300;

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [CFG_IDX_W-1:0]          cfg_index = '0;
	logic [CFG_DATA_W-1:0]         cfg_data  = '0;
	logic                          in_valid  = 1'b0;
	logic                          in_ready;
	logic signed [DEF_SAMPLE_BITS-1:0] sample_in = '0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic signed [DEF_SAMPLE_BITS-1:0] sample_out;

	iir_direct_form1_filter dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample_out (sample_out)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// filter model state: configuration and history rings
	// ------------------------------------------------------------------
	int unsigned                        taps_in_use;
	logic signed [COEF_BITS-1:0]        fwd_coef  [NTAPS];
	logic signed [COEF_BITS-1:0]        back_coef [NTAPS];  // entry 0 unused
	logic signed [DEF_SAMPLE_BITS-1:0]  x_hist    [NTAPS];
	logic signed [DEF_SAMPLE_BITS-1:0]  y_hist    [NTAPS];
	int unsigned                        ring_pos;
	int unsigned                        fill_level;

	// outputs still owed by the filter, oldest first
	logic signed [DEF_SAMPLE_BITS-1:0]  expected_out [$];

	int fail_count    = 0;
	int samples_sent  = 0;
	int results_seen  = 0;
	int reg_writes    = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	// long output stall request, picked up and counted by the receiver
	bit hold_req  = 1'b0;
	int hold_left = 0;

	function automatic void clear_history();
		for (int i = 0; i < NTAPS; i++) begin
			x_hist[i] = '0;
			y_hist[i] = '0;
		end
		ring_pos   = 0;
		fill_level = 0;
	endfunction

	// register write as the filter sees it
	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		int unsigned n;
		if (idx == REG_TAP_COUNT) begin
			// out-of-range tap counts clamp into 1..NTAPS, and history restarts
			n = 32'(data[TAP_CFG_W-1:0]);
			if (n < 1) n = 1;
			if (n > NTAPS) n = NTAPS;
			taps_in_use = n;
			clear_history();
		end else if (idx < REG_BACK_COEF_1) begin
			fwd_coef[idx - REG_FWD_COEF_0] = data;
		end else begin
			back_coef[idx - REG_BACK_COEF_1 + 1] = data;
		end
	endfunction

	// one sample through the filter: returns y[n], updates the rings
	function automatic logic signed [DEF_SAMPLE_BITS-1:0] filter_predict(
			input logic signed [DEF_SAMPLE_BITS-1:0] x);
		int unsigned slot;
		longint      acc;
		longint      y;
		acc = 0;
		x_hist[ring_pos] = x;
		if (fill_level < taps_in_use) fill_level++;
		for (int k = 0; k < taps_in_use; k++) begin
			slot = (ring_pos + taps_in_use - k) % taps_in_use;
			// lags beyond the samples seen so far count as zero
			if (k <= fill_level) begin
				acc += longint'(x_hist[slot]) * longint'(fwd_coef[k]);
				if (k > 0) acc -= longint'(y_hist[slot]) * longint'(back_coef[k]);
			end
		end
		// round half up, then saturate
		y = (acc + ROUND_HALF) >>> FRAC;
		if (y > SAMPLE_MAX) y = SAMPLE_MAX;
		if (y < SAMPLE_MIN) y = SAMPLE_MIN;
		y_hist[ring_pos] = y[DEF_SAMPLE_BITS-1:0];
		ring_pos = (ring_pos + 1) % taps_in_use;
		return y[DEF_SAMPLE_BITS-1:0];
	endfunction

	// ------------------------------------------------------------------
	// driving tasks
	// ------------------------------------------------------------------

	// one input beat, after a random idle gap; valid stays high afterwards
	// so back-to-back beats never drop it
	task automatic send_sample(input logic signed [DEF_SAMPLE_BITS-1:0] x);
		int gap;
		gap = 0;
		while (gap < 16 && $urandom_range(99) < send_idle_pct) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_in <= x;
		in_valid  <= 1'b1;
		do @(posedge clk); while (in_ready !== 1'b1);
		expected_out.push_back(filter_predict(x));
		samples_sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		apply_reg(idx, data);
		reg_writes++;
	endtask

	// stop sending, wait for every owed output, then let the pipe settle
	task automatic wait_drained();
		int guard;
		guard = 0;
		in_valid <= 1'b0;
		while (expected_out.size() != 0 && guard < 50000) begin
			@(posedge clk);
			guard++;
		end
		if (expected_out.size() != 0) begin
			$display("%0t: %0d outputs never arrived", $time, expected_out.size());
			fail_count++;
			expected_out.delete();
		end
		// settle time before the next phase
		repeat (12) @(posedge clk);
	endtask

	// full register set; the tap write (and its history clear) is optional,
	// and unused upper bits of the tap word carry random junk
	task automatic program_filter(input bit set_taps, input logic [2:0] taps_raw,
			input logic signed [COEF_BITS-1:0] b0, b1, b2, b3, a1, a2, a3);
		logic [CFG_DATA_W-1:0] tap_word;
		tap_word = CFG_DATA_W'($urandom);
		tap_word[TAP_CFG_W-1:0] = taps_raw;
		if (set_taps) write_reg(REG_TAP_COUNT, tap_word);
		write_reg(REG_FWD_COEF_0,                 b0);
		write_reg(CFG_IDX_W'(REG_FWD_COEF_0 + 1), b1);
		write_reg(CFG_IDX_W'(REG_FWD_COEF_0 + 2), b2);
		write_reg(CFG_IDX_W'(REG_FWD_COEF_0 + 3), b3);
		write_reg(REG_BACK_COEF_1,                 a1);
		write_reg(CFG_IDX_W'(REG_BACK_COEF_1 + 1), a2);
		write_reg(CFG_IDX_W'(REG_BACK_COEF_1 + 2), a3);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic signed [DEF_SAMPLE_BITS-1:0] pick_sample();
		case ($urandom_range(9))
			0:       return 16'sh7fff;
			1:       return 16'sh8000;
			2, 3:    return DEF_SAMPLE_BITS'($urandom_range(512) - 256);
			default: return DEF_SAMPLE_BITS'($urandom);
		endcase
	endfunction

	// feedforward taps anywhere in range
	function automatic logic signed [COEF_BITS-1:0] pick_fwd_coef();
		case ($urandom_range(5))
			0:       return 16'sh7fff;
			1:       return 16'sh8000;
			2:       return '0;
			3:       return COEF_BITS'($urandom);
			default: return COEF_BITS'($urandom_range(16384) - 8192);
		endcase
	endfunction

	// feedback taps mostly small so the loop stays stable, rarely at the rails
	function automatic logic signed [COEF_BITS-1:0] pick_back_coef();
		case ($urandom_range(11))
			0:       return 16'sh7fff;
			1:       return 16'sh8000;
			2:       return COEF_BITS'($urandom);
			3:       return '0;
			default: return COEF_BITS'($urandom_range(8192) - 4096);
		endcase
	endfunction

	// ------------------------------------------------------------------
	// receiver: random or held-off ready, checks every output beat
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid === 1'b1 && out_ready) begin
				results_seen++;
				if (expected_out.size() == 0) begin
					$display("%0t: output beat with nothing owed, got %0d", $time, sample_out);
					fail_count++;
				end else if (sample_out !== expected_out[0]) begin
					$display("%0t: sample_out mismatch, expected %0d, got %0d",
						$time, expected_out[0], sample_out);
					fail_count++;
					void'(expected_out.pop_front());
				end else begin
					void'(expected_out.pop_front());
				end
			end
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// reset state is a four-tap pass-through: b0 = 1.0, everything else zero
	task automatic test_reset_defaults();
		send_sample(16'sh7fff);
		send_sample(16'sh8000);
		send_sample(-16'sd1);
		send_sample(16'sd1);
		wait_drained();
	endtask

	// b0 = 0.5 on one tap (written as 0, clamped to 1) puts every odd input
	// on a tie; then full-scale taps drive the output into both rails
	task automatic test_rounding_and_saturation();
		program_filter(1'b1, 3'd0, 16'sd8192, '0, '0, '0, '0, '0, '0);
		send_sample(16'sd1);
		send_sample(-16'sd1);
		send_sample(16'sd3);
		send_sample(-16'sd3);
		wait_drained();
		// tap count 7 clamps to four
		program_filter(1'b1, 3'd7, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, '0, '0, '0);
		send_sample(16'sh7fff);
		send_sample(16'sh8000);
		send_sample(16'sd0);
		wait_drained();
		// most negative feedforward taps, full-scale feedback taps, tap count 6 clamps to four
		program_filter(1'b1, 3'd6, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
			16'sh7fff, 16'sh7fff, 16'sh7fff);
		send_sample(16'sh8000);
		send_sample(16'sh7fff);
		wait_drained();
	endtask

	// two-tap accumulator y = x + y[n-1] runs into both rails, then a
	// coefficient-only rewrite must keep the history it built
	task automatic test_feedback_and_history();
		program_filter(1'b1, 3'd2, 16'sd16384, '0, '0, '0, -16'sd16384, '0, '0);
		send_sample(16'sd20000);
		send_sample(16'sd20000);
		send_sample(16'sd20000);
		send_sample(16'sh8000);
		send_sample(16'sh8000);
		wait_drained();
		program_filter(1'b0, 3'd0, 16'sd16384, '0, '0, '0, 16'sd16384, '0, '0);
		send_sample(16'sd100);
		send_sample(16'sd100);
		wait_drained();
	endtask

	// random filters and samples under one idle mix
	task automatic test_random_traffic(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (int s = 0; s < 6; s++) begin
			program_filter(1'b1, 3'($urandom_range(7)),
				pick_fwd_coef(), pick_fwd_coef(), pick_fwd_coef(), pick_fwd_coef(),
				pick_back_coef(), pick_back_coef(), pick_back_coef());
			for (int i = 0; i < 90; i++) begin
				// now and then retune the taps mid-stream, history kept
				if (i == 45 && $urandom_range(1)) begin
					wait_drained();
					program_filter(1'b0, 3'd0,
						pick_fwd_coef(), pick_fwd_coef(), pick_fwd_coef(), pick_fwd_coef(),
						pick_back_coef(), pick_back_coef(), pick_back_coef());
				end
				send_sample(pick_sample());
			end
			wait_drained();
		end
	endtask

	// receiver holds off while beats keep coming, so the filter fills up and
	// stalls its input; then the sender waits for a full drain and resumes
	task automatic test_output_stall();
		send_idle_pct = 0;
		recv_idle_pct = 20;
		program_filter(1'b1, 3'd3, pick_fwd_coef(), pick_fwd_coef(), pick_fwd_coef(), '0,
			pick_back_coef(), pick_back_coef(), '0);
		hold_req = 1'b1;
		for (int i = 0; i < 40; i++) send_sample(pick_sample());
		wait_drained();
		for (int i = 0; i < 10; i++) send_sample(pick_sample());
		wait_drained();
	endtask

	initial begin
		taps_in_use = NTAPS;
		for (int i = 0; i < NTAPS; i++) begin
			fwd_coef[i]  = '0;
			back_coef[i] = '0;
		end
		fwd_coef[0] = 16'sd16384;
		clear_history();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_rounding_and_saturation();
		test_feedback_and_history();
		test_random_traffic(35, 55);
		test_random_traffic(55, 35);
		test_random_traffic(0, 0);
		test_output_stall();

		$display("run: %0d samples filtered, %0d outputs checked, %0d register writes",
			samples_sent, results_seen, reg_writes);
		$display("run: tap counts 1 to 4 incl. clamped writes, ties, rails, feedback, stalls");
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

[filelist.f]
rtl/iirdf1_pkg.sv
rtl/iirdf1_ram.sv
rtl/iir_direct_form1_filter.sv
bench/tb_top.sv
